@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge out of reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/lmi_pkg.sv @@
package lmi_pkg;
    localparam int SumWidthDefault = 32;
    localparam int RegWidth = 48;
    localparam int RegCount = 8;
    localparam int RegIdxWidth = 3;
    localparam int DivWidth = 64;
    localparam int DivCntWidth = 7;
    localparam int MulCycles = 4;

    localparam logic [2:0] R_CMIN = 3'd0;
    localparam logic [2:0] R_CMAX = 3'd1;
    localparam logic [2:0] R_KT = 3'd2;
    localparam logic [2:0] R_DCH = 3'd3;
    localparam logic [2:0] R_DPU = 3'd4;
    localparam logic [2:0] R_DNH = 3'd5;
    localparam logic [2:0] R_DPH = 3'd6;
    localparam logic [2:0] R_FLOOR = 3'd7;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_CAND = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [1:0] KIND_CHARGED = 2'd0;
    localparam logic [1:0] KIND_NEUTRAL = 2'd1;
    localparam logic [1:0] KIND_PHOTON = 2'd2;

    localparam logic [1:0] SET_MUON = 2'd0;
    localparam logic [1:0] SET_BARREL = 2'd1;
    localparam logic [1:0] SET_ENDCAP = 2'd2;

    localparam logic [11:0] BarrelEtaLimit = 12'd370;
    localparam logic [12:0] PiQ = 13'd804;
    localparam logic [12:0] TwoPiQ = 13'd1608;
    // ceil(2^28 / 9): exact divide by 9 for 24-bit operands
    localparam logic [24:0] EaRecip = 25'd29826162;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_KT,
        ST_MUL,
        ST_DIV_ISO,
        ST_OUT
    } lmi_state_t;

    typedef struct packed {
        logic load_lepton;
        logic candidate;
        logic start_kt_div;
        logic start_mul;
        logic start_iso_div;
        logic finish_cone;
        logic finish_result;
    } lmi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic is_muon;
        logic result_valid;
    } lmi_status_t;

    function automatic logic [15:0] ea_lookup(input logic [11:0] ae);
        logic [15:0] v;
        if (ae < 12'd205) v = 16'd4817;
        else if (ae < 12'd333) v = 16'd4057;
        else if (ae < 12'd512) v = 16'd3047;
        else if (ae < 12'd564) v = 16'd2838;
        else if (ae < 12'd640) v = 16'd3781;
        else v = 16'd0;
        return v;
    endfunction
endpackage

@@ hw/rtl/lmi_divider.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module lmi_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lmi_pkg::DivWidth-1:0] dividend,
    input  logic [lmi_pkg::DivWidth-1:0] divisor,
    output logic                         done,
    output logic [lmi_pkg::DivWidth-1:0] quotient
);
    import lmi_pkg::*;

    logic [DivWidth-1:0] quot_reg, quot_next;
    logic [DivWidth-1:0] rem_reg, rem_next;
    logic [DivWidth-1:0] dsr_reg, dsr_next;
    logic [DivCntWidth-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DivWidth:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quot_reg[DivWidth-1]};
        if (start) begin
            quot_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DivCntWidth'(DivWidth);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DivWidth'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[DivWidth-2:0], 1'b1};
            end else begin
                rem_next = trial[DivWidth-1:0];
                quot_next = {quot_reg[DivWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quot_reg;
endmodule

@@ hw/rtl/lmi_ctrl.sv @@
module lmi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [1:0]           in_action,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  lmi_pkg::lmi_status_t status,
    output lmi_pkg::lmi_cmd_t    cmd
);
    import lmi_pkg::*;

    lmi_state_t state_reg, state_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        mcnt_next = mcnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_action == ACT_BEGIN) state_next = ST_DIV_KT;
                else if (accept && in_action == ACT_FINISH) begin
                    if (status.is_muon) begin
                        state_next = ST_MUL;
                        mcnt_next = '0;
                    end else state_next = ST_DIV_ISO;
                end
            end
            ST_DIV_KT: if (status.div_done) state_next = ST_IDLE;
            ST_MUL: begin
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'(MulCycles - 1)) state_next = ST_DIV_ISO;
            end
            ST_DIV_ISO: if (status.div_done) state_next = ST_OUT;
            // quotient holds in the divider until the output register is free
            ST_OUT: if (!status.result_valid || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load_lepton = accept && in_action == ACT_BEGIN;
                cmd.start_kt_div = accept && in_action == ACT_BEGIN;
                cmd.candidate = accept && in_action == ACT_CAND;
                cmd.start_mul = accept && in_action == ACT_FINISH && status.is_muon;
                cmd.start_iso_div = accept && in_action == ACT_FINISH && !status.is_muon;
            end
            ST_DIV_KT: cmd.finish_cone = status.div_done;
            ST_MUL: cmd.start_iso_div = (mcnt_reg == 2'(MulCycles - 1));
            ST_DIV_ISO: ;
            ST_OUT: cmd.finish_result = !status.result_valid || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mcnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            mcnt_reg <= mcnt_next;
        end
    end
endmodule

@@ hw/rtl/lmi_datapath.sv @@
module lmi_datapath #(
    parameter int SUM_WIDTH = lmi_pkg::SumWidthDefault
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lmi_pkg::RegIdxWidth-1:0]      cfg_index,
    input  logic [lmi_pkg::RegWidth-1:0]         cfg_data,
    input  logic signed [11:0]                   in_eta,
    input  logic signed [11:0]                   in_phi,
    input  logic [15:0]                          in_pt,
    input  logic [15:0]                          in_rho,
    input  logic [1:0]                           in_kind,
    input  logic                                 in_primary,
    input  logic                                 out_ready,
    input  lmi_pkg::lmi_cmd_t                    cmd,
    output lmi_pkg::lmi_status_t                 status,
    output logic                                 out_valid,
    output logic [15:0]                          out_rel_iso,
    output logic                                 out_saturated
);
    import lmi_pkg::*;

    localparam logic [SUM_WIDTH-1:0] SumMax = '1;

    logic [RegWidth-1:0] cfg_reg [RegCount];
    logic signed [11:0] eta_reg, phi_reg;
    logic [15:0] lpt_reg, rho_reg, cone_reg;
    logic [1:0] set_reg;
    logic [SUM_WIDTH-1:0] ch_reg, pu_reg, nh_reg, ph_reg;
    logic [SUM_WIDTH-1:0] ch_next, pu_next, nh_next, ph_next;
    logic [15:0] rel_reg;
    logic sat_reg, valid_reg, valid_next;
    logic [31:0] m1_reg;
    logic [31:0] m2_reg;
    logic [60:0] p_reg;
    logic [47:0] ea_scaled;
    logic [23:0] ea_t_reg;
    logic [48:0] ea_prod;
    logic [20:0] ea_sub_reg;
    logic [1:0] set_new;
    logic [11:0] ae_in, ae_lep;
    logic [DivWidth-1:0] div_a, div_b, div_q;
    logic div_start, div_done;
    logic signed [12:0] de, dp_raw, dp;
    logic [25:0] dr2;
    logic [31:0] cone2;
    logic in_cone, above_floor;
    logic [SUM_WIDTH:0] nsum;
    logic [SUM_WIDTH:0] nsub;
    logic [SUM_WIDTH+1:0] total;
    logic [15:0] q16, cmin, cmax, cr;

    function automatic logic [15:0] lane(input logic [RegWidth-1:0] r, input logic [1:0] s);
        logic [15:0] v;
        case (s)
            SET_MUON: v = r[15:0];
            SET_BARREL: v = r[31:16];
            SET_ENDCAP: v = r[47:32];
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                     input logic [15:0] v);
        logic [SUM_WIDTH:0] r;
        r = {1'b0, s} + {{(SUM_WIDTH-15){1'b0}}, v};
        return r[SUM_WIDTH] ? SumMax : r[SUM_WIDTH-1:0];
    endfunction

    assign ae_in = in_eta[11] ? 12'(-in_eta) : in_eta;
    assign ae_lep = eta_reg[11] ? 12'(-eta_reg) : eta_reg;
    assign set_new = (in_rho != 16'd0) ? SET_MUON
                   : ((ae_in < BarrelEtaLimit) ? SET_BARREL : SET_ENDCAP);

    // candidate geometry
    assign de = 13'(in_eta) - 13'(eta_reg);
    assign dp_raw = 13'(in_phi) - 13'(phi_reg);
    always_comb begin
        if (dp_raw > $signed(PiQ)) dp = dp_raw - $signed(TwoPiQ);
        else if (dp_raw < -$signed(PiQ)) dp = dp_raw + $signed(TwoPiQ);
        else dp = dp_raw;
    end
    assign dr2 = 26'(de * de) + 26'(dp * dp);
    assign cone2 = cone_reg * cone_reg;
    assign in_cone = {dr2, 8'd0} < {2'b0, cone2};
    assign above_floor = in_pt > lane(cfg_reg[R_FLOOR], set_reg);

    always_comb begin
        ch_next = ch_reg;
        pu_next = pu_reg;
        nh_next = nh_reg;
        ph_next = ph_reg;
        if (cmd.load_lepton) begin
            ch_next = '0; pu_next = '0; nh_next = '0; ph_next = '0;
        end else if (cmd.candidate && in_cone) begin
            case (in_kind)
                KIND_CHARGED: begin
                    if (in_primary) begin
                        if (dr2 > 26'(lane(cfg_reg[R_DCH], set_reg)))
                            ch_next = sat_add(ch_reg, in_pt);
                    end else if (above_floor && dr2 > 26'(lane(cfg_reg[R_DPU], set_reg))) begin
                        pu_next = sat_add(pu_reg, in_pt);
                    end
                end
                KIND_NEUTRAL:
                    if (above_floor && dr2 > 26'(lane(cfg_reg[R_DNH], set_reg)))
                        nh_next = sat_add(nh_reg, in_pt);
                KIND_PHOTON:
                    if (above_floor && dr2 > 26'(lane(cfg_reg[R_DPH], set_reg)))
                        ph_next = sat_add(ph_reg, in_pt);
                default: ;
            endcase
        end
    end

    // finish arithmetic: a muon subtracts the effective-area term from the pipe below
    assign nsum = {1'b0, nh_reg} + {1'b0, ph_reg};
    always_comb begin
        logic [DivWidth-1:0] sub;
        sub = (rho_reg != 16'd0) ? DivWidth'(ea_sub_reg) : DivWidth'(pu_reg);
        nsub = (DivWidth'(nsum) > sub) ? (SUM_WIDTH+1)'(DivWidth'(nsum) - sub) : '0;
    end
    assign total = {1'b0, ch_reg} + {1'b0, nsub};

    // (p >> 20) * 100, then >> 24 and divide by 9 through the reciprocal
    assign ea_scaled = 48'({p_reg[60:20], 6'd0}) + 48'({p_reg[60:20], 5'd0})
                     + 48'({p_reg[60:20], 2'd0});
    assign ea_prod = 49'(ea_t_reg) * 49'(EaRecip);

    always_comb begin
        div_start = cmd.start_kt_div || cmd.start_iso_div;
        if (cmd.start_kt_div) begin
            div_a = DivWidth'({lane(cfg_reg[R_KT], set_new), 12'd0});
            div_b = DivWidth'(in_pt);
        end else begin
            div_a = DivWidth'({total, 12'd0});
            div_b = DivWidth'(lpt_reg);
        end
    end

    lmi_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        q16 = (lpt_reg == 16'd0 || div_q > 64'hFFFF) ? 16'hFFFF : div_q[15:0];
        cmin = lane(cfg_reg[R_CMIN], set_reg);
        cmax = lane(cfg_reg[R_CMAX], set_reg);
        cr = (q16 > cmax) ? cmax : q16;
        if (cr < cmin) cr = cmin;
    end

    always_comb begin
        valid_next = valid_reg;
        if (out_valid && out_ready) valid_next = 1'b0;
        if (cmd.finish_result) valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RegCount; i++) cfg_reg[i] <= '0;
            eta_reg <= '0; phi_reg <= '0; lpt_reg <= '0; rho_reg <= '0;
            set_reg <= SET_MUON; cone_reg <= '0;
            ch_reg <= '0; pu_reg <= '0; nh_reg <= '0; ph_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) cfg_reg[cfg_index] <= cfg_data;
            if (cmd.load_lepton) begin
                eta_reg <= in_eta; phi_reg <= in_phi; lpt_reg <= in_pt;
                rho_reg <= in_rho; set_reg <= set_new;
            end
            if (cmd.finish_cone) cone_reg <= cr;
            ch_reg <= ch_next; pu_reg <= pu_next; nh_reg <= nh_next; ph_reg <= ph_next;
            valid_reg <= valid_next;
        end
        // rho*ea*cone^2 and its scaling over a short pipe
        if (cmd.start_mul) m1_reg <= cone_reg * cone_reg;
        m2_reg <= 32'(rho_reg * ea_lookup(ae_lep));
        p_reg <= 61'(m2_reg) * 61'(m1_reg);
        ea_t_reg <= ea_scaled[47:24];
        ea_sub_reg <= ea_prod[48:28];
        if (cmd.finish_result) begin
            if (lpt_reg == 16'd0 || div_q > 64'hFFFF) begin
                rel_reg <= 16'hFFFF; sat_reg <= 1'b1;
            end else begin
                rel_reg <= div_q[15:0]; sat_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.mul_done = 1'b0;
    assign status.is_muon = rho_reg != 16'd0;
    assign status.result_valid = valid_reg;
    assign out_valid = valid_reg;
    assign out_rel_iso = rel_reg;
    assign out_saturated = sat_reg;
endmodule

@@ hw/rtl/lepton_mini_isolation_core.sv @@
// Candidates: one transfer per cycle while no begin or finish is busy, no result.
// Begin: a 64-step cone radius divide, input held off meanwhile.
// Finish: for an electron the 64-step divide, for a muon a multiply and scale first,
// then the divide; input is held off until the result goes to the output register.
// Candidates and begins pass while a result waits; a finish waits for the output.
// aresetn synchronous active low clears configuration, lepton state and sums.
module lepton_mini_isolation_core #(
    parameter int SUM_WIDTH = lmi_pkg::SumWidthDefault
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lmi_pkg::RegIdxWidth-1:0]  cfg_index,
    input  logic [lmi_pkg::RegWidth-1:0]     cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[1:0], eta[13:2], phi[25:14], pt[41:26], rho[57:42], particle_kind[59:58],
    // from_primary_vertex[60], zero pad
    input  logic [63:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rel_iso[15:0]
    output logic [15:0]                      m_tdata,
    // saturated[0]
    output logic                             m_tuser
);
    import lmi_pkg::*;

    lmi_cmd_t cmd;
    lmi_status_t status;

    lmi_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_action(s_tdata[1:0]),
        .in_ready(s_tready), .out_ready(m_tready), .status(status), .cmd(cmd)
    );

    lmi_datapath #(.SUM_WIDTH(SUM_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_eta(s_tdata[13:2]), .in_phi(s_tdata[25:14]),
        .in_pt(s_tdata[41:26]), .in_rho(s_tdata[57:42]), .in_kind(s_tdata[59:58]),
        .in_primary(s_tdata[60]), .out_ready(m_tready), .cmd(cmd), .status(status),
        .out_valid(m_tvalid), .out_rel_iso(m_tdata), .out_saturated(m_tuser)
    );
endmodule

@@ hw/rtl/lmi_checker.sv @@
module lmi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    import lmi_pkg::*;
    `include "assert_macros.svh"

    logic acc_begin, acc_finish;

    assign acc_begin = s_tvalid && s_tready && s_tdata[1:0] == ACT_BEGIN;
    assign acc_finish = s_tvalid && s_tready && s_tdata[1:0] == ACT_FINISH;

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `ASSERT_IMPL(a_sat, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 16'hFFFF, "saturated not max")
    `ASSERT_NEXT(a_begin, aclk, aresetn, acc_begin, !s_tready, "begin not stalled")
    `ASSERT_NEXT(a_fin, aclk, aresetn, acc_finish, !m_tvalid || !$past(m_tready), "finish result too early")
endmodule

bind lepton_mini_isolation_core lmi_checker u_chk (.*);

@@ verif/testbench.sv @@
module testbench;
    import lmi_pkg::*;

    typedef struct packed {
        logic [15:0] rel_iso;
        logic        saturated;
    } iso_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    lepton_mini_isolation_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // shadow state of the isolation core
    logic [47:0] regs [8];
    logic signed [11:0] lep_eta, lep_phi;
    logic [15:0] lep_pt, lep_rho, cone_r;
    logic [1:0]  pset;
    logic [63:0] sum_ch, sum_pu, sum_nh, sum_ph;

    iso_result_t iso_queue[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  drained = 0;

    function automatic logic [63:0] lane_of(input logic [2:0] r);
        if (pset > 2) return 0;
        return (regs[r] >> (16 * pset)) & 64'hFFFF;
    endfunction

    function automatic logic [63:0] sum_add(input logic [63:0] s, input logic [15:0] v);
        logic [63:0] r;
        r = s + v;
        return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
    endfunction

    task automatic predict_isolation(input logic [63:0] d);
        logic [1:0] act, kind;
        logic signed [11:0] eta, phi;
        logic [15:0] pt;
        logic signed [63:0] de, dp;
        logic [63:0] q, cmin, cmax, dr2, sub, nsum, total, ratio, prod, ea;
        logic [11:0] ae;
        iso_result_t res;
        act = d[1:0]; eta = d[13:2]; phi = d[25:14]; pt = d[41:26]; kind = d[59:58];
        if (act == ACT_BEGIN) begin
            lep_eta = eta; lep_phi = phi; lep_pt = pt; lep_rho = d[57:42];
            ae = eta < 0 ? -eta : eta;
            pset = lep_rho != 0 ? SET_MUON : (ae < BarrelEtaLimit ? SET_BARREL : SET_ENDCAP);
            if (pt == 0) q = 64'hFFFF;
            else begin
                q = (lane_of(R_KT) << 12) / pt;
                if (q > 64'hFFFF) q = 64'hFFFF;
            end
            cmin = lane_of(R_CMIN); cmax = lane_of(R_CMAX);
            if (q > cmax) q = cmax;
            if (q < cmin) q = cmin;
            cone_r = q[15:0];
            sum_ch = 0; sum_pu = 0; sum_nh = 0; sum_ph = 0;
        end else if (act == ACT_CAND) begin
            de = 64'(eta) - 64'(lep_eta);
            dp = 64'(phi) - 64'(lep_phi);
            if (dp > 804) dp -= 1608;
            else if (dp < -804) dp += 1608;
            dr2 = de * de + dp * dp;
            if ((dr2 << 8) < 64'(cone_r) * cone_r) begin
                if (kind == KIND_CHARGED) begin
                    if (d[60]) begin
                        if (dr2 > lane_of(R_DCH)) sum_ch = sum_add(sum_ch, pt);
                    end else if (pt > lane_of(R_FLOOR) && dr2 > lane_of(R_DPU))
                        sum_pu = sum_add(sum_pu, pt);
                end else if (kind == KIND_NEUTRAL) begin
                    if (pt > lane_of(R_FLOOR) && dr2 > lane_of(R_DNH))
                        sum_nh = sum_add(sum_nh, pt);
                end else if (kind == KIND_PHOTON) begin
                    if (pt > lane_of(R_FLOOR) && dr2 > lane_of(R_DPH))
                        sum_ph = sum_add(sum_ph, pt);
                end
            end
        end else if (act == ACT_FINISH) begin
            if (lep_rho != 0) begin
                ae = lep_eta < 0 ? -lep_eta : lep_eta;
                if (ae < 205) ea = 4817;
                else if (ae < 333) ea = 4057;
                else if (ae < 512) ea = 3047;
                else if (ae < 564) ea = 2838;
                else if (ae < 640) ea = 3781;
                else ea = 0;
                prod = 64'(lep_rho) * ea * (64'(cone_r) * cone_r);
                sub = ((prod >> 20) * 100) / (64'd9 << 24);
            end else sub = sum_pu;
            nsum = sum_nh + sum_ph;
            nsum = nsum > sub ? nsum - sub : 0;
            total = sum_ch + nsum;
            if (lep_pt == 0) res = '{16'hFFFF, 1'b1};
            else begin
                ratio = (total << 12) / lep_pt;
                if (ratio > 64'hFFFF) res = '{16'hFFFF, 1'b1};
                else res = '{ratio[15:0], 1'b0};
            end
            iso_queue.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        regs[idx] = val;
    endtask

    task automatic wait_idle();
        while (iso_queue.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic send_item(input logic [63:0] d);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1; s_tdata = d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_isolation(d);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [63:0] pack_item(input logic [1:0] act, input logic [11:0] eta,
            input logic [11:0] phi, input logic [15:0] pt, input logic [15:0] rho,
            input logic [1:0] kind, input logic prim);
        return {3'b0, prim, kind, rho, pt, phi, eta, act};
    endfunction

    // mostly a near-lepton candidate so the cone and dead cones get exercised
    task automatic send_candidate(input bit wild);
        logic [11:0] e, p;
        if (wild) begin
            e = $urandom; p = $urandom;
        end else begin
            e = lep_eta + $urandom_range(0, 80) - 40;
            p = lep_phi + $urandom_range(0, 80) - 40;
        end
        send_item(pack_item(ACT_CAND, e, p, $urandom_range(0, 3) == 0 ? $urandom :
            $urandom_range(0, 2000), $urandom, $urandom, $urandom));
    endtask

    task automatic send_lepton(input bit muon);
        send_item(pack_item(ACT_BEGIN, $urandom_range(0, 800) - 400, $urandom,
            $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(16, 3000),
            muon ? $urandom_range(1, 65535) : 16'd0, $urandom, $urandom));
    endtask

    task automatic load_settings(input int mode);
        for (int r = 0; r < 8; r++) begin
            logic [47:0] v;
            case (mode)
                0: v = '0;
                1: v = '1;
                default: v = {$urandom, $urandom};
            endcase
            if (mode == 2) begin
                if (r == R_CMIN) v = {3{16'($urandom_range(0, 600))}};
                if (r == R_CMAX) v = {3{16'($urandom_range(1200, 4000))}};
                if (r == R_KT) v = {3{16'($urandom_range(100, 3000))}};
                if (r >= R_DCH && r <= R_DPH) v = {3{16'($urandom_range(0, 300))}};
                if (r == R_FLOOR) v = {3{16'($urandom_range(0, 400))}};
            end
            write_reg(r[2:0], v);
        end
    endtask

    task automatic test_directed();
        load_settings(2);
        // finish and candidate before any lepton, then an unused action
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(ACT_CAND, 0, 0, 100, 0, KIND_CHARGED, 1));
        send_item(pack_item(2'd3, 12'hFFF, 12'hFFF, '1, '1, '1, 1));
        // zero-pt electron, then barrel/endcap boundaries and phi wrap
        send_item(pack_item(ACT_BEGIN, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(ACT_BEGIN, 12'd369, 12'd800, 16'd320, 0, 0, 0));
        send_item(pack_item(ACT_CAND, 12'd370, -12'sd800, 16'hFFFF, 0, KIND_CHARGED, 1));
        send_item(pack_item(ACT_CAND, 12'd369, 12'd805, 16'd500, 0, KIND_CHARGED, 0));
        send_item(pack_item(ACT_CAND, 12'd372, 12'd799, 16'd700, 0, KIND_NEUTRAL, 0));
        send_item(pack_item(ACT_CAND, 12'd366, 12'd801, 16'd900, 0, KIND_PHOTON, 1));
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(ACT_BEGIN, -12'sd370, -12'sd2048, 16'd1, 0, 0, 0));
        send_item(pack_item(ACT_CAND, -12'sd370, 12'd2047, 16'hFFFF, 0, KIND_PHOTON, 0));
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        // muons with eta in several of the effective-area bins
        for (int b = 0; b < 6; b++) begin
            send_item(pack_item(ACT_BEGIN, 12'(b * 128 - 1), 0, 16'd480, 16'hFFFF, 0, 0));
            send_item(pack_item(ACT_CAND, 12'(b * 128), 0, 16'd2000, 0, KIND_NEUTRAL, 1));
            send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        end
    endtask

    task automatic test_register_extremes();
        // all-ones: cone limits at the maximum, the dead cone keeps these candidates out of the sums
        wait_idle();
        load_settings(1);
        send_item(pack_item(ACT_BEGIN, 0, 0, 16'd16, 0, 0, 0));
        repeat (4) send_item(pack_item(ACT_CAND, 0, 0, 16'hFFFF, 0, KIND_CHARGED, 1));
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        wait_idle();
        load_settings(0);
        send_lepton(1);
        send_candidate(0);
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
        wait_idle();
        // cone_min above cone_max
        write_reg(R_CMIN, {3{16'd3000}});
        write_reg(R_CMAX, {3{16'd100}});
        write_reg(R_KT, {3{16'd800}});
        send_lepton(0);
        send_candidate(0);
        send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_events();
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            load_settings(ph == 5 ? 3 : 2);
            for (int ev = 0; ev < 12; ev++) begin
                if (ph >= 4) quiet = 1;
                if ($urandom_range(0, 9) == 0)
                    send_item(pack_item($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
                send_lepton($urandom_range(0, 1));
                repeat ($urandom_range(2, 10)) send_candidate($urandom_range(0, 5) == 0);
                send_item(pack_item(ACT_FINISH, 0, 0, 0, 0, 0, 0));
                if (ev == 3) wait_idle();
            end
        end
    endtask

    initial begin
        for (int r = 0; r < 8; r++) regs[r] = '0;
        lep_eta = 0; lep_phi = 0; lep_pt = 0; lep_rho = 0; pset = 0; cone_r = 0;
        sum_ch = 0; sum_pu = 0; sum_nh = 0; sum_ph = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_register_extremes();
        test_random_events();
        wait_idle();
        drained = 1;
    end

    // result sink with random backpressure
    always @(negedge aclk) begin
        if (!aresetn || quiet) m_tready <= 1'b1;
        else if ($urandom_range(0, 4) == 0) m_tready <= 1'b0;
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        iso_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (iso_queue.size() == 0) begin
                $display("%0t: unexpected result rel_iso=%h sat=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_r = iso_queue.pop_front();
                if (m_tdata !== exp_r.rel_iso || m_tuser !== exp_r.saturated) begin
                    $display("%0t: expected rel_iso=%h sat=%b, actual rel_iso=%h sat=%b",
                        $time, exp_r.rel_iso, exp_r.saturated, m_tdata, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (drained) begin
            if (errors == 0 && iso_queue.size() == 0) $display("PASS lepton_mini_isolation_core");
            else $display("FAIL lepton_mini_isolation_core");
            $finish;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("FAIL lepton_mini_isolation_core");
                $finish;
            end
        end
    end
endmodule
